// ----- src/time_of_day_byte_encoder_defines.svh -----
// Assertion macros used by the checker file.
`ifndef TIME_OF_DAY_BYTE_ENCODER_DEFINES_SVH
`define TIME_OF_DAY_BYTE_ENCODER_DEFINES_SVH

// Checked property, off while reset is high.
`define TDBE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also live during reset.
`define TDBE_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tdbe_pkg.sv -----
package tdbe_pkg;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [5:0] SECOND_MAX = 6'd60;

  localparam logic [9:0] NS_PER_STEP = 10'd1000;

  // floor(x / 1000) = (x * RECIP) >> SHIFT, exact over the operand range
  localparam logic [30:0] US_RECIP = 31'd1099511628;
  localparam int          US_SHIFT = 40;
  localparam logic [20:0] MS_RECIP = 21'd1073742;
  localparam int          MS_SHIFT = 30;

  localparam int ENTRY_BITS = 88;

  typedef enum logic [1:0] {
    MAG_NONE = 2'd0,
    MAG_MS   = 2'd1,
    MAG_US   = 2'd2,
    MAG_NS   = 2'd3
  } mag_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [29:0] ns;
    logic        zone;
    logic [13:0] lat;
    logic [14:0] lon;
  } time_fields_t;

  typedef struct packed {
    logic [ENTRY_BITS-1:0] data;
    logic [3:0]            count;
  } entry_t;

endpackage

// ----- src/tdbe_ifs.sv -----
interface tdbe_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  hour_value;
  logic [5:0]  minute_value;
  logic [5:0]  second_value;
  logic [29:0] nanosecond_value;
  logic        zone_kind;
  logic [13:0] latitude_bits;
  logic [14:0] longitude_bits;

  modport source (
    output valid, hour_value, minute_value, second_value, nanosecond_value,
           zone_kind, latitude_bits, longitude_bits,
    input  ready
  );
  modport sink (
    input  valid, hour_value, minute_value, second_value, nanosecond_value,
           zone_kind, latitude_bits, longitude_bits,
    output ready
  );
endinterface

interface tdbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

// ----- src/time_of_day_byte_encoder.sv -----
// Encodes one time of day per request into 3 to 11 little-endian bytes, the final
// byte flagged by last_byte. Bytes leave at one per cycle from the serializer while
// the receiver is ready; an item has 3, 4, 5 or 7 bytes for subsecond magnitude 0
// to 3, plus 4 for a latitude/longitude zone. The front end classifies the
// nanoseconds through a three-stage reciprocal-multiply divider, and an item passes
// those stages, the queue and the serializer's output register before its first
// byte shows; up to QUEUE_DEPTH encoded items wait between front and serializer,
// and new requests are taken while earlier items are still going out.
module time_of_day_byte_encoder
  import tdbe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  tdbe_in_if.sink    time_chan,
  tdbe_out_if.source byte_chan
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          push, pop, nonempty;
  entry_t        push_entry, head;
  logic [CW-1:0] q_count;

  tdbe_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .time_chan  (time_chan),
    .q_count    (q_count),
    .push       (push),
    .push_entry (push_entry)
  );

  tdbe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .nonempty   (nonempty),
    .count      (q_count)
  );

  tdbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .byte_chan (byte_chan)
  );

endmodule

// ----- src/tdbe_front.sv -----
module tdbe_front
  import tdbe_pkg::*;
#(
  parameter int DEPTH = 4,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  tdbe_in_if.sink       time_chan,
  input  logic [CW-1:0] q_count,
  output logic          push,
  output entry_t        push_entry
);

  logic         va, vb, vc;
  time_fields_t fa, fb, fc;
  logic [60:0]  p1;
  logic [20:0]  q;
  logic [41:0]  p2;
  logic         r1nz;

  logic [CW+1:0] inflight;
  logic          accept;
  time_fields_t  fin;

  logic [20:0] qb;
  logic [29:0] qb_scaled;
  logic [10:0] q2;
  logic [20:0] q2_scaled;
  logic        r2nz;
  mag_t        mag;
  logic [29:0] sub;
  logic [2:0]  nb;
  logic [49:0] base;
  logic [31:0] zw;
  logic [ENTRY_BITS-1:0] zdata;

  assign inflight = (CW+2)'(q_count) + (CW+2)'(va) + (CW+2)'(vb) + (CW+2)'(vc);
  assign time_chan.ready = inflight < (CW+2)'(DEPTH);
  assign accept = time_chan.valid && time_chan.ready;

  always_comb begin
    fin.hour   = (time_chan.hour_value > HOUR_MAX) ? HOUR_MAX : time_chan.hour_value;
    fin.minute = (time_chan.minute_value > MINUTE_MAX) ? MINUTE_MAX
                                                       : time_chan.minute_value;
    fin.second = (time_chan.second_value > SECOND_MAX) ? SECOND_MAX
                                                       : time_chan.second_value;
    fin.ns     = time_chan.nanosecond_value;
    fin.zone   = time_chan.zone_kind;
    fin.lat    = time_chan.latitude_bits;
    fin.lon    = time_chan.longitude_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= accept;
      vb <= va;
      vc <= vb;
    end
  end

  assign qb        = p1[US_SHIFT+20:US_SHIFT];
  assign qb_scaled = 30'(qb) * 30'(NS_PER_STEP);

  always_ff @(posedge clk) begin
    fa   <= fin;
    fb   <= fa;
    p1   <= 61'(fa.ns) * 61'(US_RECIP);
    fc   <= fb;
    q    <= qb;
    r1nz <= fb.ns != qb_scaled;
    p2   <= 42'(qb) * 42'(MS_RECIP);
  end

  // second divide by 1000 gives ns / 1e6
  assign q2        = p2[MS_SHIFT+10:MS_SHIFT];
  assign q2_scaled = 21'(q2) * 21'(NS_PER_STEP);
  assign r2nz      = q != q2_scaled;

  always_comb begin
    if (fc.ns == '0) begin
      mag = MAG_NONE;
    end else if (r1nz) begin
      mag = MAG_NS;
    end else if (r2nz) begin
      mag = MAG_US;
    end else begin
      mag = MAG_MS;
    end
  end

  assign zw = {2'b0, fc.lon, fc.lat, 1'b1};

  always_comb begin
    case (mag)
      MAG_NONE: begin
        sub   = '0;
        nb    = 3'd3;
        zdata = ENTRY_BITS'(zw) << 24;
      end
      MAG_MS: begin
        sub   = {20'b0, q2[9:0]};
        nb    = 3'd4;
        zdata = ENTRY_BITS'(zw) << 32;
      end
      MAG_US: begin
        sub   = {10'b0, q[19:0]};
        nb    = 3'd5;
        zdata = ENTRY_BITS'(zw) << 40;
      end
      default: begin
        sub   = fc.ns;
        nb    = 3'd7;
        zdata = ENTRY_BITS'(zw) << 56;
      end
    endcase
  end

  assign base = {sub, fc.second, fc.minute, fc.hour, mag, ~fc.zone};

  assign push             = vc;
  assign push_entry.data  = ENTRY_BITS'(base) | (fc.zone ? zdata : '0);
  assign push_entry.count = 4'(nb) + (fc.zone ? 4'd4 : 4'd0);

endmodule

// ----- src/tdbe_queue.sv -----
module tdbe_queue
  import tdbe_pkg::*;
#(
  parameter int DEPTH = 4,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int PW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  entry_t        push_entry,
  input  logic          pop,
  output entry_t        head,
  output logic          nonempty,
  output logic [CW-1:0] count
);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wptr, rptr;

  assign head     = slots[rptr];
  assign nonempty = count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

endmodule

// ----- src/tdbe_back.sv -----
module tdbe_back
  import tdbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       nonempty,
  input  entry_t     head,
  output logic       pop,
  tdbe_out_if.source byte_chan
);

  logic                  busy;
  logic [ENTRY_BITS-1:0] shreg;
  logic [3:0]            rem;
  logic                  ovalid;
  logic [7:0]            obyte;
  logic                  olast;
  logic                  can_emit, emit, finishing;

  assign can_emit  = !ovalid || byte_chan.ready;
  assign emit      = busy && can_emit;
  assign finishing = emit && (rem == 4'd1);
  assign pop       = nonempty && (!busy || finishing);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (emit) begin
        ovalid <= 1'b1;
      end else if (byte_chan.ready) begin
        ovalid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obyte <= shreg[7:0];
      olast <= rem == 4'd1;
    end
    if (pop) begin
      shreg <= head.data;
      rem   <= head.count;
    end else if (emit) begin
      shreg <= shreg >> 8;
      rem   <= rem - 4'd1;
    end
  end

  assign byte_chan.valid     = ovalid;
  assign byte_chan.out_byte  = obyte;
  assign byte_chan.last_byte = olast;

endmodule

// ----- src/tdbe_checker.sv -----
`include "time_of_day_byte_encoder_defines.svh"

module tdbe_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  logic       acc;
  logic [3:0] run;

  assign acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else if (acc) begin
      run <= out_last ? 4'd0 : run + 4'd1;
    end
  end

  `TDBE_CHECK_ALWAYS(a_reset_idle, rst |=> !out_valid, "output valid after reset")
  `TDBE_CHECK(a_valid_hold, out_valid && !out_ready |=> out_valid, "valid dropped on stall")
  `TDBE_CHECK(a_max_bytes, acc && run == 4'd10 |-> out_last, "more than 11 bytes in item")
  `TDBE_CHECK(a_min_bytes, acc && run < 4'd2 |-> !out_last, "fewer than 3 bytes in item")

endmodule

bind time_of_day_byte_encoder tdbe_checker u_tdbe_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (byte_chan.valid),
  .out_ready (byte_chan.ready),
  .out_last  (byte_chan.last_byte)
);

// ----- dv/time_of_day_byte_encoder_tb.sv -----
module time_of_day_byte_encoder_tb;
  import tdbe_pkg::*;

  localparam int unsigned NS_PER_US = 1000;
  localparam int unsigned NS_PER_MS = 1000000;
  localparam logic ZONE_UTC = 1'b0;
  localparam logic ZONE_LATLONG = 1'b1;
  localparam int RANDOM_ITEMS = 400;
  localparam int SHOWN_FAULTS = 10;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } coded_byte_t;

  // lit_count of zero: expected bytes come from the encoder model
  typedef struct packed {
    time_fields_t t;
    logic [3:0]   lit_count;
    logic [87:0]  lit_bytes;
  } time_row_t;

  logic clk = 1'b0;
  logic rst;
  logic [8:0] stall_phase = '0;

  tdbe_in_if  time_if ();
  tdbe_out_if byte_if ();

  coded_byte_t pending_bytes[$];
  time_row_t   directed_rows[$];
  int          byte_faults = 0;
  int          burst_left = 0;

  time_of_day_byte_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .time_chan (time_if),
    .byte_chan (byte_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void encode_time_bytes(input time_fields_t t);
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    mag_t        mag;
    logic [31:0] quot;
    logic [29:0] sub;
    logic [63:0] word;
    logic [31:0] zone_word;
    int          n_bytes;
    hour   = (t.hour > HOUR_MAX) ? HOUR_MAX : t.hour;
    minute = (t.minute > MINUTE_MAX) ? MINUTE_MAX : t.minute;
    second = (t.second > SECOND_MAX) ? SECOND_MAX : t.second;
    if (t.ns == '0) begin
      mag = MAG_NONE;
    end else if ((t.ns % NS_PER_US) != 0) begin
      mag = MAG_NS;
    end else if ((t.ns % NS_PER_MS) != 0) begin
      mag = MAG_US;
    end else begin
      mag = MAG_MS;
    end
    sub = '0;
    case (mag)
      MAG_MS: begin
        quot = t.ns / NS_PER_MS;
        sub[9:0] = quot[9:0];
      end
      MAG_US: begin
        quot = t.ns / NS_PER_US;
        sub[19:0] = quot[19:0];
      end
      MAG_NS: begin
        sub = t.ns;
      end
      default: begin
        sub = '0;
      end
    endcase
    word = '0;
    word[49:0] = {sub, second, minute, hour, mag, t.zone == ZONE_UTC};
    n_bytes = (27 + 10 * int'(mag)) / 8;
    for (int i = 0; i < n_bytes; i++) begin
      pending_bytes.push_back({word[8*i +: 8], t.zone == ZONE_UTC && i == n_bytes - 1});
    end
    if (t.zone == ZONE_LATLONG) begin
      zone_word = {2'b00, t.lon, t.lat, 1'b1};
      for (int i = 0; i < 4; i++) begin
        pending_bytes.push_back({zone_word[8*i +: 8], i == 3});
      end
    end
  endfunction

  function automatic time_row_t time_row(input logic [4:0] hour, input logic [5:0] minute,
                                         input logic [5:0] second, input logic [29:0] ns,
                                         input logic zone, input logic [13:0] lat,
                                         input logic [14:0] lon, input logic [3:0] lit_count,
                                         input logic [87:0] lit_bytes);
    time_row_t r;
    r.t.hour = hour;
    r.t.minute = minute;
    r.t.second = second;
    r.t.ns = ns;
    r.t.zone = zone;
    r.t.lat = lat;
    r.t.lon = lon;
    r.lit_count = lit_count;
    r.lit_bytes = lit_bytes;
    return r;
  endfunction

  function automatic time_fields_t random_time();
    time_fields_t t;
    t.hour = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    t.minute = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
    t.second = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 60));
    case ($urandom_range(0, 4))
      0: t.ns = '0;
      1: t.ns = 30'($urandom_range(1, 1073) * NS_PER_MS);
      2: t.ns = 30'($urandom_range(1, 1073741) * NS_PER_US);
      3: t.ns = 30'($urandom_range(0, 999999999));
      default: t.ns = 30'($urandom);
    endcase
    t.zone = 1'($urandom);
    t.lat = 14'($urandom);
    t.lon = 15'($urandom);
    return t;
  endfunction

  // called at a rising edge; returns at the edge that takes the request
  task automatic offer_time(input time_fields_t t, input logic [3:0] lit_count,
                            input logic [87:0] lit_bytes);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        time_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    time_if.valid <= 1'b1;
    time_if.hour_value <= t.hour;
    time_if.minute_value <= t.minute;
    time_if.second_value <= t.second;
    time_if.nanosecond_value <= t.ns;
    time_if.zone_kind <= t.zone;
    time_if.latitude_bits <= t.lat;
    time_if.longitude_bits <= t.lon;
    do @(negedge clk); while (!time_if.ready);
    if (lit_count == 0) begin
      encode_time_bytes(t);
    end else begin
      for (int i = 0; i < lit_count; i++) begin
        pending_bytes.push_back({lit_bytes[8*i +: 8], i == lit_count - 1});
      end
    end
    @(posedge clk);
    burst_left--;
  endtask

  // receiver: full rate, light random stalls, periodic stalls, heavy stalls
  always @(posedge clk) begin
    stall_phase <= stall_phase + 9'd1;
    case (stall_phase[8:7])
      2'd0: byte_if.ready <= 1'b1;
      2'd1: byte_if.ready <= ($urandom_range(0, 3) != 0);
      2'd2: byte_if.ready <= (stall_phase[1:0] != 2'b11);
      default: byte_if.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // outputs sampled mid-cycle; a byte seen here is taken at the next rising edge
  always @(negedge clk) begin
    coded_byte_t want;
    if (!rst && byte_if.valid && byte_if.ready) begin
      if (pending_bytes.size() == 0) begin
        byte_faults++;
        if (byte_faults <= SHOWN_FAULTS) begin
          $display("unexpected byte %02h last %0b", byte_if.out_byte, byte_if.last_byte);
        end
      end else begin
        want = pending_bytes.pop_front();
        if (byte_if.out_byte !== want.data || byte_if.last_byte !== want.last) begin
          byte_faults++;
          if (byte_faults <= SHOWN_FAULTS) begin
            $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                     want.data, want.last, byte_if.out_byte, byte_if.last_byte);
          end
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst = 1'b1;
    time_if.valid = 1'b0;
    time_if.hour_value = '0;
    time_if.minute_value = '0;
    time_if.second_value = '0;
    time_if.nanosecond_value = '0;
    time_if.zone_kind = ZONE_UTC;
    time_if.latitude_bits = '0;
    time_if.longitude_bits = '0;
    byte_if.ready = 1'b0;

    // all zero, utc and zone
    directed_rows.push_back(time_row(0, 0, 0, 0, ZONE_UTC, 0, 0, 3, 88'h000001));
    directed_rows.push_back(time_row(0, 0, 0, 0, ZONE_LATLONG, 0, 0, 7, 88'h01000000));
    // top of range, then clamped fields
    directed_rows.push_back(time_row(23, 59, 60, 0, ZONE_UTC, 0, 0, 3, 88'h0F3BB9));
    directed_rows.push_back(time_row(31, 63, 63, 0, ZONE_UTC, 0, 0, 3, 88'h0F3BB9));
    directed_rows.push_back(time_row(24, 60, 61, 0, ZONE_UTC, 0, 0, 3, 88'h0F3BB9));
    // subsecond magnitudes and their edges
    directed_rows.push_back(time_row(1, 2, 3, 1, ZONE_UTC, 0, 0, 0, '0));
    directed_rows.push_back(time_row(4, 5, 6, 999, ZONE_UTC, 0, 0, 0, '0));
    directed_rows.push_back(time_row(7, 8, 9, 1000, ZONE_UTC, 0, 0, 0, '0));
    directed_rows.push_back(time_row(10, 11, 12, 999000, ZONE_UTC, 0, 0, 0, '0));
    directed_rows.push_back(time_row(13, 14, 15, 1000000, ZONE_UTC, 0, 0, 0, '0));
    directed_rows.push_back(time_row(16, 17, 18, 999000000, ZONE_UTC, 0, 0, 0, '0));
    directed_rows.push_back(time_row(19, 20, 21, 999999999, ZONE_UTC, 0, 0, 0, '0));
    // nanoseconds past one second, scaled value wider than its field
    directed_rows.push_back(time_row(22, 23, 24, 1000000000, ZONE_UTC, 0, 0, 0, '0));
    directed_rows.push_back(time_row(23, 59, 60, 30'h3FFFFFFF, ZONE_UTC, 0, 0, 0, '0));
    directed_rows.push_back(time_row(0, 30, 30, 1073000000, ZONE_UTC, 0, 0, 0, '0));
    directed_rows.push_back(time_row(12, 0, 59, 1073741000, ZONE_UTC, 0, 0, 0, '0));
    // zone word extremes; utc ignores lat/long
    directed_rows.push_back(time_row(0, 0, 0, 0, ZONE_LATLONG, 14'h3FFF, 15'h7FFF, 7,
                                     88'h3FFFFFFF000000));
    directed_rows.push_back(time_row(0, 0, 0, 0, ZONE_UTC, 14'h3FFF, 15'h7FFF, 3, 88'h000001));
    directed_rows.push_back(time_row(31, 63, 63, 30'h3FFFFFFF, ZONE_LATLONG, 14'h3FFF,
                                     15'h7FFF, 0, '0));
    directed_rows.push_back(time_row(5, 6, 7, 123456789, ZONE_LATLONG, 1, 0, 0, '0));
    directed_rows.push_back(time_row(8, 9, 10, 5000, ZONE_LATLONG, 0, 1, 0, '0));
    directed_rows.push_back(time_row(20, 45, 60, 7000000, ZONE_LATLONG, 14'h2AAA, 15'h5555,
                                     0, '0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_time(directed_rows[i].t, directed_rows[i].lit_count, directed_rows[i].lit_bytes);
    end
    repeat (RANDOM_ITEMS) begin
      offer_time(random_time(), 4'd0, 88'd0);
    end
    time_if.valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (byte_faults == 0 && pending_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
